FILE: sv/bitcrusher_audio_effect_top_defines.svh
// ----------------------------------------------------------------------------
// Bitcrusher assertion macros
// Shared concurrent assertion forms for the bitcrusher RTL.
// ----------------------------------------------------------------------------
`ifndef BITCRUSHER_AUDIO_EFFECT_TOP_DEFINES_SVH
`define BITCRUSHER_AUDIO_EFFECT_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BCFX_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BCFX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/bcfx_pkg.sv
// ----------------------------------------------------------------------------
// Bitcrusher package
// Widths, register indexes, reset values and helpers shared by the bitcrusher.
// ----------------------------------------------------------------------------
`default_nettype none

package bcfx_pkg;

    localparam int SAMPLE_W     = 24;
    localparam int FRAC         = SAMPLE_W - 1;
    localparam int CHANNELS_DEF = 2;

    localparam int MUL_W   = 34;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int A_W     = 26;
    localparam int X2_W    = 28;
    localparam int X4_W    = 33;
    localparam int X6_W    = 37;
    localparam int P_W     = 44;
    localparam int Q_W     = 46;
    localparam int DIVIDEND_W = 64;
    localparam int DIVISOR_W  = Q_W - 3;
    localparam int QUO_W   = 25;
    localparam int QV_W    = 18;
    localparam int ACC_W   = 42;
    localparam int Z_W     = SAMPLE_W + 1;
    localparam int MAG_W   = 48;
    localparam int CNT_W   = 7;

    localparam int DRIVE_W = 16;
    localparam int SCALE_W = 24;
    localparam int RECIP_W = 25;
    localparam int MIX_W   = 17;
    localparam int GAIN_W  = 16;
    localparam int CFG_DATA_W = 25;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANT_SCALE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANT_RECIP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_PERIOD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WET_MIX     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_GAIN = 3'd5;

    localparam logic [DRIVE_W-1:0] DRIVE_UNITY = 16'd4096;
    localparam logic [SCALE_W-1:0] SCALE_RST   = 24'd32768;
    localparam logic [RECIP_W-1:0] RECIP_RST   = 25'd131072;
    localparam logic [CNT_W-1:0]   PERIOD_RST  = 7'd1;
    localparam logic [MIX_W-1:0]   MIX_UNITY   = 17'd65536;
    localparam logic [GAIN_W-1:0]  GAIN_RST    = 16'd4096;

    localparam int C_P0 = 135135;
    localparam int C_P2 = 17325;
    localparam int C_P4 = 378;
    localparam int C_Q2 = 62370;
    localparam int C_Q4 = 3150;

    typedef struct packed {
        logic [DRIVE_W-1:0] drive_gain;
        logic [SCALE_W-1:0] quant_scale;
        logic [RECIP_W-1:0] quant_recip;
        logic [CNT_W-1:0]   hold_period;
        logic [MIX_W-1:0]   wet_mix;
        logic [GAIN_W-1:0]  output_gain;
    } cfg_t;

    function automatic logic signed [SAMPLE_W-1:0] sat_sample(
        input logic [MAG_W-1:0] mag, input logic neg);
        logic signed [SAMPLE_W-1:0] res;
        if (neg) begin
            if (mag >= (MAG_W'(1) << FRAC)) begin
                res = {1'b1, {FRAC{1'b0}}};
            end else begin
                res = -$signed(mag[SAMPLE_W-1:0]);
            end
        end else begin
            if (mag > MAG_W'({FRAC{1'b1}})) begin
                res = {1'b0, {FRAC{1'b1}}};
            end else begin
                res = $signed(mag[SAMPLE_W-1:0]);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: sv/bcfx_mul.sv
// ----------------------------------------------------------------------------
// Bitcrusher shared multiplier
// Signed multiplier with a registered product, reused by every multiply step.
// ----------------------------------------------------------------------------
`default_nettype none

module bcfx_mul (
    input  wire logic                                aclk,
    input  wire logic signed [bcfx_pkg::MUL_W-1:0]   op_a,
    input  wire logic signed [bcfx_pkg::MUL_W-1:0]   op_b,
    output logic signed [bcfx_pkg::PROD_W-1:0]       prod
);
    import bcfx_pkg::*;

    always_ff @(posedge aclk) begin
        prod <= op_a * op_b;
    end

endmodule

`default_nettype wire

FILE: sv/bcfx_div.sv
// ----------------------------------------------------------------------------
// Bitcrusher divider
// Restoring divider producing one quotient bit per cycle for the tanh ratio.
// ----------------------------------------------------------------------------
`default_nettype none

module bcfx_div (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              start,
    input  wire logic [bcfx_pkg::DIVIDEND_W-1:0]   dividend,
    input  wire logic [bcfx_pkg::DIVISOR_W-1:0]    divisor,
    output logic                                   done,
    output logic [bcfx_pkg::QUO_W-1:0]             quotient
);
    import bcfx_pkg::*;

    localparam int STEP_W = $clog2(QUO_W);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0] den_reg, den_next;
    logic [QUO_W-1:0]     low_reg, low_next;
    logic [QUO_W-1:0]     quo_reg, quo_next;
    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W:0]   diff;
    logic                 fits;

    always_comb begin
        trial = {rem_reg, low_reg[QUO_W-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = trial >= {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = DIVISOR_W'(dividend[DIVIDEND_W-1:QUO_W]);
            low_next  = dividend[QUO_W-1:0];
            den_next  = divisor;
        end else if (busy_reg) begin
            rem_next  = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quo_next  = {quo_reg[QUO_W-2:0], fits};
            low_next  = {low_reg[QUO_W-2:0], 1'b0};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(QUO_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg <= step_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        low_reg  <= low_next;
        quo_reg  <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

FILE: sv/bcfx_core.sv
// ----------------------------------------------------------------------------
// Bitcrusher sequencer
// Steps one sample through drive (when drive gain exceeds unity), quantize,
// hold, mix and gain on the shared multiplier and divider.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bitcrusher_audio_effect_top_defines.svh"

module bcfx_core #(
    parameter int CHANNELS = bcfx_pkg::CHANNELS_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire bcfx_pkg::cfg_t                        cfg,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic signed [bcfx_pkg::SAMPLE_W-1:0]  in_sample,
    input  wire logic                                  in_channel,
    input  wire logic                                  out_free,
    output logic                                       res_valid,
    output logic signed [bcfx_pkg::SAMPLE_W-1:0]       res_sample
);
    import bcfx_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [4:0] {
        S_IDLE, S_DRV_MUL, S_DRV_RND, S_X2_MUL, S_X2_GET, S_X4_MUL, S_X4_GET,
        S_X6_MUL, S_X6_GET, S_P1_MUL, S_P1_ACC, S_P2_MUL, S_P2_ACC,
        S_Q1_MUL, S_Q1_ACC, S_Q2_MUL, S_Q2_ACC, S_DIV_START, S_DIV_WAIT,
        S_T_MUL, S_T_GET, S_QNT_MUL, S_QNT_RND, S_RCP_MUL, S_RCP_RND,
        S_MIX_A, S_MIX_B, S_MIX_C, S_GAIN_MUL, S_GAIN_RND
    } state_t;

    state_t                       state_reg, state_next;
    logic signed [SAMPLE_W-1:0]   x_reg, x_next;
    logic [CH_W-1:0]              ch_reg, ch_next;
    logic                         neg_reg, neg_next;
    logic [SAMPLE_W-1:0]          pmag_reg, pmag_next;
    logic [A_W-1:0]               a_reg, a_next;
    logic [X2_W-1:0]              x2_reg, x2_next;
    logic [X4_W-1:0]              x4_reg, x4_next;
    logic [X6_W-1:0]              x6_reg, x6_next;
    logic [P_W-1:0]               pacc_reg, pacc_next;
    logic [Q_W-1:0]               qacc_reg, qacc_next;
    logic [QUO_W-1:0]             r_reg, r_next;
    logic [QV_W-1:0]              qv_reg, qv_next;
    logic signed [SAMPLE_W-1:0]   w_reg, w_next;
    logic signed [ACC_W-1:0]      acc_reg, acc_next;
    logic signed [Z_W-1:0]        z_reg, z_next;
    logic [CNT_W-1:0]             cnt_reg [CHANNELS];
    logic [CNT_W-1:0]             cnt_next [CHANNELS];
    logic signed [SAMPLE_W-1:0]   held_reg [CHANNELS];
    logic signed [SAMPLE_W-1:0]   held_next [CHANNELS];
    logic                         res_valid_next;
    logic signed [SAMPLE_W-1:0]   res_sample_next;

    logic signed [MUL_W-1:0]      mul_a, mul_b;
    logic signed [PROD_W-1:0]     prod;
    logic                         div_start, div_done;
    logic [QUO_W-1:0]             div_quo;
    logic                         in_fire;

    logic [MIX_W-1:0]             wm;
    logic [40:0]                  drv_rnd;
    logic [48:0]                  qnt_rnd;
    logic [43:0]                  rcp_rnd;
    logic signed [SAMPLE_W-1:0]   y_val;
    logic [CNT_W-1:0]             cnt_inc;
    logic signed [ACC_W-1:0]      mix_sum;
    logic [ACC_W-1:0]             mix_mag;
    logic [ACC_W-1:0]             mix_rnd;
    logic [ACC_W-1:0]             gain_mag;
    logic [ACC_W-1:0]             gain_rnd;

    bcfx_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    bcfx_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({pacc_reg, 20'd0}),
        .divisor  (qacc_reg[Q_W-1:3]),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign div_start = (state_reg == S_DIV_START);
    assign wm        = (cfg.wet_mix > MIX_UNITY) ? MIX_UNITY : cfg.wet_mix;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_DRV_MUL: begin
                mul_a = MUL_W'(pmag_reg);
                mul_b = MUL_W'(cfg.drive_gain);
            end
            S_X2_MUL: begin
                mul_a = MUL_W'(a_reg);
                mul_b = MUL_W'(a_reg);
            end
            S_X4_MUL: begin
                mul_a = MUL_W'(x2_reg);
                mul_b = MUL_W'(x2_reg);
            end
            S_X6_MUL: begin
                mul_a = MUL_W'(x4_reg);
                mul_b = MUL_W'(x2_reg);
            end
            S_P1_MUL: begin
                mul_a = MUL_W'(x2_reg);
                mul_b = MUL_W'(C_P2);
            end
            S_P2_MUL: begin
                mul_a = MUL_W'(x4_reg);
                mul_b = MUL_W'(C_P4);
            end
            S_Q1_MUL: begin
                mul_a = MUL_W'(x2_reg);
                mul_b = MUL_W'(C_Q2);
            end
            S_Q2_MUL: begin
                mul_a = MUL_W'(x4_reg);
                mul_b = MUL_W'(C_Q4);
            end
            S_T_MUL: begin
                mul_a = MUL_W'(r_reg);
                mul_b = MUL_W'(a_reg);
            end
            S_QNT_MUL: begin
                mul_a = MUL_W'(pmag_reg);
                mul_b = MUL_W'(cfg.quant_scale);
            end
            S_RCP_MUL: begin
                mul_a = MUL_W'(qv_reg);
                mul_b = MUL_W'(cfg.quant_recip);
            end
            S_MIX_A: begin
                mul_a = MUL_W'(w_reg);
                mul_b = MUL_W'(wm);
            end
            S_MIX_B: begin
                mul_a = MUL_W'(x_reg);
                mul_b = MUL_W'(MIX_UNITY - wm);
            end
            S_GAIN_MUL, S_GAIN_RND: begin
                mul_a = MUL_W'(z_reg);
                mul_b = MUL_W'(cfg.output_gain);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        drv_rnd  = prod[40:0] + 41'd2048;
        qnt_rnd  = prod[48:0] + (49'd1 << 30);
        rcp_rnd  = prod[43:0] + 44'd1;
        y_val    = sat_sample(MAG_W'(rcp_rnd[43:1]), neg_reg);
        cnt_inc  = cnt_reg[ch_reg] + CNT_W'(1);
        mix_sum  = acc_reg + prod[ACC_W-1:0];
        mix_mag  = mix_sum[ACC_W-1] ? ACC_W'(-mix_sum) : ACC_W'(mix_sum);
        mix_rnd  = (mix_mag + ACC_W'(32768)) >> 16;
        gain_mag = prod[ACC_W-1] ? ACC_W'(-prod[ACC_W-1:0]) : ACC_W'(prod[ACC_W-1:0]);
        gain_rnd = (gain_mag + ACC_W'(2048)) >> 12;
    end

    always_comb begin
        state_next = state_reg;
        x_next    = x_reg;
        ch_next   = ch_reg;
        neg_next  = neg_reg;
        pmag_next = pmag_reg;
        a_next    = a_reg;
        x2_next   = x2_reg;
        x4_next   = x4_reg;
        x6_next   = x6_reg;
        pacc_next = pacc_reg;
        qacc_next = qacc_reg;
        r_next    = r_reg;
        qv_next   = qv_reg;
        w_next    = w_reg;
        acc_next  = acc_reg;
        z_next    = z_reg;
        cnt_next  = cnt_reg;
        held_next = held_reg;
        res_valid_next  = 1'b0;
        res_sample_next = sat_sample(MAG_W'(gain_rnd), prod[ACC_W-1]);
        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    x_next    = in_sample;
                    ch_next   = (CHANNELS > 1) ? CH_W'(in_channel) : '0;
                    neg_next  = in_sample[SAMPLE_W-1];
                    pmag_next = in_sample[SAMPLE_W-1] ? SAMPLE_W'(-in_sample)
                                                       : SAMPLE_W'(in_sample);
                    state_next = (cfg.drive_gain > DRIVE_UNITY) ? S_DRV_MUL : S_QNT_MUL;
                end
            end
            S_DRV_MUL:  state_next = S_DRV_RND;
            S_DRV_RND: begin
                if (drv_rnd[40:12] >= (29'd5 << FRAC)) begin
                    pmag_next  = {1'b0, {FRAC{1'b1}}};
                    state_next = S_QNT_MUL;
                end else begin
                    a_next     = drv_rnd[12 +: A_W];
                    state_next = S_X2_MUL;
                end
            end
            S_X2_MUL:  state_next = S_X2_GET;
            S_X2_GET: begin
                x2_next    = prod[FRAC +: X2_W];
                state_next = S_X4_MUL;
            end
            S_X4_MUL:  state_next = S_X4_GET;
            S_X4_GET: begin
                x4_next    = prod[FRAC +: X4_W];
                state_next = S_X6_MUL;
            end
            S_X6_MUL:  state_next = S_X6_GET;
            S_X6_GET: begin
                x6_next    = prod[FRAC +: X6_W];
                state_next = S_P1_MUL;
            end
            S_P1_MUL:  state_next = S_P1_ACC;
            S_P1_ACC: begin
                pacc_next  = (P_W'(C_P0) << FRAC) + prod[P_W-1:0];
                state_next = S_P2_MUL;
            end
            S_P2_MUL:  state_next = S_P2_ACC;
            S_P2_ACC: begin
                pacc_next  = pacc_reg + prod[P_W-1:0] + P_W'(x6_reg);
                state_next = S_Q1_MUL;
            end
            S_Q1_MUL:  state_next = S_Q1_ACC;
            S_Q1_ACC: begin
                qacc_next  = (Q_W'(C_P0) << FRAC) + prod[Q_W-1:0];
                state_next = S_Q2_MUL;
            end
            S_Q2_MUL:  state_next = S_Q2_ACC;
            S_Q2_ACC: begin
                qacc_next  = qacc_reg + prod[Q_W-1:0] + (Q_W'(x6_reg) << 4)
                             + (Q_W'(x6_reg) << 3) + (Q_W'(x6_reg) << 2);
                state_next = S_DIV_START;
            end
            S_DIV_START: state_next = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (div_done) begin
                    r_next     = div_quo;
                    state_next = S_T_MUL;
                end
            end
            S_T_MUL:   state_next = S_T_GET;
            S_T_GET: begin
                if (|prod[PROD_W-1:2*FRAC]) begin
                    pmag_next = {1'b0, {FRAC{1'b1}}};
                end else begin
                    pmag_next = {1'b0, prod[2*FRAC-1:FRAC]};
                end
                state_next = S_QNT_MUL;
            end
            S_QNT_MUL: state_next = S_QNT_RND;
            S_QNT_RND: begin
                qv_next    = qnt_rnd[48:31];
                state_next = S_RCP_MUL;
            end
            S_RCP_MUL: state_next = S_RCP_RND;
            S_RCP_RND: begin
                w_next = y_val;
                if (cfg.hold_period > CNT_W'(1)) begin
                    if (cnt_inc >= cfg.hold_period) begin
                        held_next[ch_reg] = y_val;
                        cnt_next[ch_reg]  = '0;
                    end else begin
                        cnt_next[ch_reg]  = cnt_inc;
                        w_next            = held_reg[ch_reg];
                    end
                end
                state_next = S_MIX_A;
            end
            S_MIX_A:   state_next = S_MIX_B;
            S_MIX_B: begin
                acc_next   = prod[ACC_W-1:0];
                state_next = S_MIX_C;
            end
            S_MIX_C: begin
                z_next = mix_sum[ACC_W-1] ? -$signed(Z_W'(mix_rnd))
                                          : $signed(Z_W'(mix_rnd));
                state_next = S_GAIN_MUL;
            end
            S_GAIN_MUL: state_next = S_GAIN_RND;
            S_GAIN_RND: begin
                if (out_free) begin
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            for (int i = 0; i < CHANNELS; i++) begin
                cnt_reg[i]  <= '0;
                held_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            held_reg  <= held_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        ch_reg   <= ch_next;
        neg_reg  <= neg_next;
        pmag_reg <= pmag_next;
        a_reg    <= a_next;
        x2_reg   <= x2_next;
        x4_reg   <= x4_next;
        x6_reg   <= x6_next;
        pacc_reg <= pacc_next;
        qacc_reg <= qacc_next;
        r_reg    <= r_next;
        qv_reg   <= qv_next;
        w_reg    <= w_next;
        acc_reg  <= acc_next;
        z_reg    <= z_next;
    end

    assign res_valid  = res_valid_next;
    assign res_sample = res_sample_next;

    `BCFX_ASSERT_NEXT(a_accept_leaves_idle, aclk, aresetn, in_fire, state_reg != S_IDLE, "transfer accepted but sequencer stayed idle")
    `BCFX_ASSERT_IMPL(a_div_done_waiting, aclk, aresetn, div_done, state_reg == S_DIV_WAIT, "divider finished outside its wait step")
    `BCFX_ASSERT_IMPL(a_div_ratio_bound, aclk, aresetn, div_done, div_quo <= (QUO_W'(1) << FRAC), "tanh ratio above unity")
    `BCFX_ASSERT_IMPL(a_result_has_room, aclk, aresetn, res_valid, out_free, "result issued while output register full")

endmodule

`default_nettype wire

FILE: sv/bitcrusher_audio_effect_top.sv
// ----------------------------------------------------------------------------
// Bitcrusher audio effect
// Drive, quantization, sample-and-hold, wet/dry mix and output gain.
// ----------------------------------------------------------------------------
// Samples enter on the s_ stream channel (Q1.23 in s_tdata, channel number in
// s_tuser) and leave on the m_ stream channel, one result per sample.
// Settings are to be written through cfg_we, cfg_index and cfg_wdata only while idle; the block does not enforce this.
// A sample passes through one shared multiplier under a sequencer. Without
// drive the sample goes through the quantize, hold, mix and gain steps, and
// the next sample is taken only once the sequencer is back in idle. With drive
// active the tanh step adds the polynomial terms and a divider run; a drive
// argument of 5.0 or more skips the tanh step and saturates the sample.
// s_tready is high only while the sequencer is idle. The result waits in an
// output register, so a new sample may be taken while m_tready is low; the
// sequencer then holds its finished result until that register is free.
// Reset loads the default settings and clears hold counters and held values.
// ----------------------------------------------------------------------------
`default_nettype none

module bitcrusher_audio_effect_top #(
    parameter int CHANNELS = bcfx_pkg::CHANNELS_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [bcfx_pkg::SAMPLE_W-1:0]        s_tdata,  // sample_in
    input  wire logic [0:0]                           s_tuser,  // channel
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [bcfx_pkg::SAMPLE_W-1:0]             m_tdata,  // sample_out
    input  wire logic                                 cfg_we,
    input  wire logic [bcfx_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [bcfx_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import bcfx_pkg::*;

    cfg_t                        cfg_reg;
    logic                        m_tvalid_reg;
    logic [SAMPLE_W-1:0]         m_tdata_reg;
    logic                        out_free;
    logic                        res_valid;
    logic signed [SAMPLE_W-1:0]  res_sample;

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.drive_gain  <= DRIVE_UNITY;
            cfg_reg.quant_scale <= SCALE_RST;
            cfg_reg.quant_recip <= RECIP_RST;
            cfg_reg.hold_period <= PERIOD_RST;
            cfg_reg.wet_mix     <= MIX_UNITY;
            cfg_reg.output_gain <= GAIN_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_DRIVE_GAIN:  cfg_reg.drive_gain  <= cfg_wdata[DRIVE_W-1:0];
                CFG_QUANT_SCALE: cfg_reg.quant_scale <= cfg_wdata[SCALE_W-1:0];
                CFG_QUANT_RECIP: cfg_reg.quant_recip <= cfg_wdata[RECIP_W-1:0];
                CFG_HOLD_PERIOD: cfg_reg.hold_period <= cfg_wdata[CNT_W-1:0];
                CFG_WET_MIX:     cfg_reg.wet_mix     <= cfg_wdata[MIX_W-1:0];
                CFG_OUTPUT_GAIN: cfg_reg.output_gain <= cfg_wdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_tdata_reg <= res_sample;
        end
    end

    bcfx_core #(
        .CHANNELS (CHANNELS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_sample  (s_tdata),
        .in_channel (s_tuser[0]),
        .out_free   (out_free),
        .res_valid  (res_valid),
        .res_sample (res_sample)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

FILE: sim/tb_bitcrusher_audio_effect_top.sv
// ----------------------------------------------------------------------------
// Bitcrusher audio effect testbench
// Streams samples through the bitcrusher under a series of register settings,
// from the extremes of every register to random ones, with bursty input and a
// stalling output. An in-bench predictor of drive, quantizer, hold, mix and
// gain supplies the expected output of every accepted transfer, and each
// output transfer is compared with the oldest expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bitcrusher_audio_effect_top;
    import bcfx_pkg::*;

    typedef struct packed {
        logic [SAMPLE_W-1:0] smp;
        logic                ch;
    } audio_item_t;

    localparam int  PHASES      = 16;
    localparam int  PER_PHASE   = 100;
    localparam int  IDLE_LIMIT  = 20000;
    localparam longint POS_MAX  = (64'sd1 <<< FRAC) - 1;
    localparam longint NEG_MIN  = -(64'sd1 <<< FRAC);

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [SAMPLE_W-1:0]  s_tdata = '0;
    logic [0:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [SAMPLE_W-1:0]  m_tdata;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    audio_item_t          pending_samples[$];
    logic [SAMPLE_W-1:0]  expected_out[$];
    cfg_t                 shadow_cfg;
    logic [CNT_W-1:0]     hold_cnt[2];
    longint               held_val[2];
    int                   n_sent = 0;
    int                   n_acc = 0;
    int                   n_out = 0;
    int                   n_err = 0;
    int                   idle_cycles = 0;
    int                   burst_left = 0;
    int                   gap_left = 0;
    int                   stall_hold = 0;
    bit                   hold_request = 1'b0;
    bit                   hold_done = 1'b0;

    bitcrusher_audio_effect_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [63:0] mag64(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] round_shift(input logic [63:0] m, input int s);
        return (m + (64'd1 << (s - 1))) >> s;
    endfunction

    function automatic longint sround_shift(input longint v, input int s);
        logic [63:0] r;
        r = round_shift(mag64(v), s);
        return v < 0 ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint clamp_sample(input longint v);
        if (v > POS_MAX) return POS_MAX;
        if (v < NEG_MIN) return NEG_MIN;
        return v;
    endfunction

    function automatic logic [63:0] tanh_mag(input logic [63:0] a);
        logic [63:0] one, x2, x4, x6, p, q, r, t;
        one = 64'd1 << 23;
        if (a >= 64'd5 * one) return one;
        x2 = (a * a) >> 23;
        x4 = (x2 * x2) >> 23;
        x6 = (x4 * x2) >> 23;
        p = 64'd135135 * one + 64'd17325 * x2 + 64'd378 * x4 + x6;
        q = 64'd135135 * one + 64'd62370 * x2 + 64'd3150 * x4 + 64'd28 * x6;
        r = (p << 20) / (q >> 3);
        t = (r * a) >> 23;
        return t > one ? one : t;
    endfunction

    function automatic logic [SAMPLE_W-1:0] crush_sample(input logic [SAMPLE_W-1:0] din,
                                                         input logic ch);
        longint      x, pv, y, w, z, wm;
        logic [63:0] m, q;
        bit          neg;
        x = longint'($signed(din));
        pv = x;
        if (shadow_cfg.drive_gain > DRIVE_UNITY) begin
            neg = pv < 0;
            m = round_shift(mag64(pv) * 64'(shadow_cfg.drive_gain), 12);
            m = tanh_mag(m);
            if (m > 64'(POS_MAX)) m = 64'(POS_MAX);
            pv = neg ? -longint'(m) : longint'(m);
        end
        neg = pv < 0;
        q = round_shift(mag64(pv) * 64'(shadow_cfg.quant_scale), FRAC + 8);
        m = round_shift(q * 64'(shadow_cfg.quant_recip), 1);
        if (m > (64'd1 << (FRAC + 1))) m = 64'd1 << (FRAC + 1);
        y = clamp_sample(neg ? -longint'(m) : longint'(m));
        w = y;
        if (shadow_cfg.hold_period > 1) begin
            hold_cnt[ch] = hold_cnt[ch] + 1'b1;
            if (hold_cnt[ch] >= shadow_cfg.hold_period) begin
                held_val[ch] = y;
                hold_cnt[ch] = '0;
            end
            w = held_val[ch];
        end
        wm = shadow_cfg.wet_mix > MIX_UNITY ? 65536 : longint'(shadow_cfg.wet_mix);
        z = sround_shift(w * wm + x * (65536 - wm), 16);
        z = clamp_sample(sround_shift(z * longint'(shadow_cfg.output_gain), 12));
        return z[SAMPLE_W-1:0];
    endfunction

    // Sender: bursts of random length separated by random gaps.
    always @(negedge aclk) begin
        if (s_tvalid && n_acc < n_sent) begin
            s_tvalid <= 1'b1;
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            s_tvalid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
            audio_item_t it;
            it = pending_samples.pop_front();
            s_tdata  <= it.smp;
            s_tuser  <= it.ch;
            s_tvalid <= 1'b1;
            n_sent   <= n_sent + 1;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 40);
                gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // Receiver: its own stall pattern, plus one long hold-off on request.
    always @(negedge aclk) begin
        if (hold_request && !hold_done) begin
            hold_done  <= 1'b1;
            stall_hold <= 400;
            m_tready   <= 1'b0;
        end else if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
            m_tready   <= 1'b0;
        end else if (n_out % 64 < 16) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 2) != 0);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_out = {expected_out, crush_sample(s_tdata, s_tuser[0])};
                n_acc <= n_acc + 1;
            end
            if (m_tvalid && m_tready) begin
                n_out <= n_out + 1;
                if (expected_out.size() == 0) begin
                    $display("%0t: unexpected output transfer, actual %h", $time, m_tdata);
                    n_err <= n_err + 1;
                end else begin
                    logic [SAMPLE_W-1:0] exp_smp;
                    exp_smp = expected_out.pop_front();
                    if (m_tdata !== exp_smp) begin
                        $display("%0t: sample_out mismatch, expected %h, actual %h",
                                 $time, exp_smp, m_tdata);
                        n_err <= n_err + 1;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("Test completed with failures");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_DRIVE_GAIN:  shadow_cfg.drive_gain  = val[DRIVE_W-1:0];
            CFG_QUANT_SCALE: shadow_cfg.quant_scale = val[SCALE_W-1:0];
            CFG_QUANT_RECIP: shadow_cfg.quant_recip = val[RECIP_W-1:0];
            CFG_HOLD_PERIOD: shadow_cfg.hold_period = val[CNT_W-1:0];
            CFG_WET_MIX:     shadow_cfg.wet_mix     = val[MIX_W-1:0];
            default:         shadow_cfg.output_gain = val[GAIN_W-1:0];
        endcase
    endtask

    task automatic queue_sample(input logic [SAMPLE_W-1:0] smp, input logic ch);
        audio_item_t it;
        it.smp = smp;
        it.ch  = ch;
        pending_samples = {pending_samples, it};
    endtask

    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 4))
            0:       return SAMPLE_W'($signed($urandom_range(0, 8191)) - 4096);
            1:       return $urandom_range(0, 1)
                            ? SAMPLE_W'(24'h7FFFFF - $urandom_range(0, 255))
                            : SAMPLE_W'(24'h800000 + $urandom_range(0, 255));
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    initial begin
        logic [CFG_DATA_W-1:0] regs[6];
        int scale_bits;
        shadow_cfg = '{DRIVE_UNITY, SCALE_RST, RECIP_RST, PERIOD_RST, MIX_UNITY, GAIN_RST};
        hold_cnt = '{default: '0};
        held_val = '{default: 0};
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: regs = '{4096, 32768, 131072, 1, 65536, 4096};
                1: regs = '{45056, 256, 16777216, 100, 0, 258};
                2: regs = '{4097, 8388608, 16777216, 2, 131071, 64917};
                3: regs = '{4096, 8388608, 33554431, 3, 65536, 65535};
                4: regs = '{20000, 0, 512, 127, 32768, 4096};
                5: regs = '{8192, 2048, 2097152, 0, 65536, 4096};
                default: begin
                    scale_bits = $urandom_range(1, 16);
                    regs[0] = CFG_DATA_W'($urandom_range(0, 1) ? 4096
                                                               : $urandom_range(4096, 45056));
                    regs[1] = CFG_DATA_W'((1 << (scale_bits + 7)) + $urandom_range(0, 255));
                    regs[2] = CFG_DATA_W'((64'd1 << 32) / regs[1]);
                    regs[3] = CFG_DATA_W'($urandom_range(0, 3) == 0 ? $urandom_range(1, 100)
                                                                    : $urandom_range(1, 6));
                    regs[4] = CFG_DATA_W'($urandom_range(0, 2) == 0 ? 65536
                                                                    : $urandom_range(0, 65536));
                    regs[5] = CFG_DATA_W'($urandom_range(258, 64917));
                end
            endcase
            for (int r = 0; r < 6; r++) write_reg(CFG_IDX_W'(r), regs[r]);

            if (ph == 0) begin
                queue_sample(24'h000000, 1'b0);
                queue_sample(24'h7FFFFF, 1'b0);
                queue_sample(24'h800000, 1'b1);
                queue_sample(24'hFFFFFF, 1'b1);
                queue_sample(24'h000001, 1'b0);
                queue_sample(24'h400000, 1'b1);
                queue_sample(24'hC00000, 1'b0);
                queue_sample(24'h555555, 1'b1);
                queue_sample(24'hAAAAAA, 1'b0);
            end
            if (ph == 1 || ph == 2) begin
                queue_sample(24'h7FFFFF, 1'b0);
                queue_sample(24'h800000, 1'b1);
                queue_sample(24'h0A0000, 1'b0);
                queue_sample(24'hF60000, 1'b1);
            end
            for (int i = 0; i < PER_PHASE; i++) queue_sample(random_sample(), 1'($urandom));
            if (ph == 3) hold_request = 1'b1;

            while (pending_samples.size() > 0 || n_acc < n_sent || expected_out.size() > 0)
                @(posedge aclk);
            repeat (80) @(posedge aclk);
        end

        $display("Ran %0d register settings, %0d samples accepted, %0d outputs checked.",
                 PHASES, n_acc, n_out);
        $display("Settings covered drive, quantizer and hold extremes, mix above unity, gains.");
        if (n_err == 0 && expected_out.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/bcfx_pkg.sv
sv/bcfx_mul.sv
sv/bcfx_div.sv
sv/bcfx_core.sv
sv/bitcrusher_audio_effect_top.sv
sim/tb_bitcrusher_audio_effect_top.sv
